// File: src/tkps_pkg.sv
package tkps_pkg;

  localparam int MAX_TOP_K_DEF      = 64;
  localparam int VOCAB_MAX_DEF      = 65536;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam int DIV_W = 40;

  localparam logic [63:0] XS_MULT   = 64'd2685821657736338717;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;

  localparam logic [15:0] TEMPERATURE_RST = 16'd256;
  localparam logic [6:0]  TOP_K_RST       = 7'd40;
  localparam logic [16:0] TOP_P_RST       = 17'd65536;
  localparam logic [15:0] PENALTY_RST     = 16'd256;
  localparam logic [63:0] SEED_RST        = 64'd1;

  typedef enum logic [2:0] {
    REG_TEMPERATURE = 3'd0,
    REG_TOP_K       = 3'd1,
    REG_TOP_P       = 3'd2,
    REG_PENALTY     = 3'd3,
    REG_SEED        = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_PEN,
    ST_KEY,
    ST_TMP,
    ST_INS,
    ST_GRD,
    ST_WMUL,
    ST_WEXP,
    ST_PRD,
    ST_PSTART,
    ST_PWAIT,
    ST_RND0,
    ST_RND1,
    ST_RND2,
    ST_RND3,
    ST_RND4,
    ST_TMUL,
    ST_SRD,
    ST_SCHK
  } state_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctrl_t;

  // One entry of the 2^(-j/2^bits) table in Q0.16, built from a series for e^(-a).
  function automatic logic [15:0] exp_entry(input int unsigned j, input int unsigned bits);
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    a    = (64'(j) * LN2_Q32) >> bits;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * a) >> 32) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = (sum + 64'd32768) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

// File: src/tkps_cell.sv
module tkps_cell (
  input  logic                   clk,
  input  tkps_pkg::cell_ctrl_t   ctrl,
  input  logic signed [31:0]     key,
  input  logic [15:0]            key_idx,
  input  logic                   occ,
  input  logic                   prev_ge,
  input  logic signed [31:0]     prev_val,
  input  logic [15:0]            prev_idx,
  input  logic signed [31:0]     next_val,
  input  logic [15:0]            next_idx,
  output logic signed [31:0]     val,
  output logic [15:0]            idx,
  output logic                   ge
);
  import tkps_pkg::*;

  assign ge = occ && (val >= key);

  always_ff @(posedge clk) begin
    if (ctrl.drain) begin
      val <= next_val;
      idx <= next_idx;
    end else if (ctrl.ins && !ge) begin
      if (prev_ge) begin
        val <= key;
        idx <= key_idx;
      end else begin
        val <= prev_val;
        idx <= prev_idx;
      end
    end
  end

endmodule

// File: src/tkps_div.sv
module tkps_div #(
  parameter int DEN_W = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [tkps_pkg::DIV_W-1:0]    num,
  input  logic [DEN_W-1:0]              den,
  output logic                          done,
  output logic [tkps_pkg::DIV_W-1:0]    quo
);
  import tkps_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;

  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= CW'(DIV_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (cnt != '0) begin
      if (shifted >= {1'b0, den_r}) begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: src/top_k_top_p_token_sampler.sv
// A word that does not end the vocabulary goes through prep, the optional penalty division,
// key, the optional temperature division and insert; the shared 40-step divider does both.
// A new word is taken only once busy falls. A final word then reads the top cell if greedy,
// else weighs each kept entry, divides each weight into a probability, draws and scans.
// Reset: synchronous and active high; registers, generator and kept list return to defaults.
// done pulses for one cycle together with token_index; the receiver cannot stall.
module top_k_top_p_token_sampler #(
  parameter int MAX_TOP_K      = tkps_pkg::MAX_TOP_K_DEF,
  parameter int VOCAB_MAX      = tkps_pkg::VOCAB_MAX_DEF,
  parameter int EXP_TABLE_BITS = tkps_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] logit,
  input  logic               seen_flag,
  input  logic               last_token,
  output logic               done,
  output logic [15:0]        token_index,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import tkps_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOP_K + 1);
  localparam int I_W   = $clog2(MAX_TOP_K);
  localparam int TC_W  = $clog2(VOCAB_MAX);
  localparam int TOT_W = 16 + $clog2(MAX_TOP_K);
  localparam int TAB   = 1 << EXP_TABLE_BITS;

  state_t state, state_next;

  logic [15:0] temperature;
  logic [6:0]  top_k;
  logic [16:0] top_p;
  logic [15:0] rep_penalty;
  logic [63:0] seed;
  logic [63:0] gen_state;

  logic signed [31:0] x_r;
  logic               seen_r;
  logic               last_r;
  logic [15:0]        idx_r;
  logic               greedy_r;
  logic [CNT_W-1:0]   k_r;
  logic signed [31:0] pen_r;
  logic signed [31:0] key_r;
  logic [CNT_W-1:0]   kept_count;
  logic [TC_W-1:0]    token_counter;
  logic [CNT_W-1:0]   n_r;
  logic [I_W-1:0]     i_r;
  logic signed [31:0] max_r;
  logic [48:0]        prod_r;
  logic [TOT_W-1:0]   total_r;
  logic [17:0]        cum_cut;
  logic [CNT_W-1:0]   active_r;
  logic               cut_done;
  logic [63:0]        rp0;
  logic [31:0]        rph;
  logic [15:0]        r_r;
  logic [32:0]        t_r;
  logic [17:0]        cum_r;

  logic [15:0] idx_mem [MAX_TOP_K];
  logic [15:0] w_mem   [MAX_TOP_K];
  logic [16:0] p_mem   [MAX_TOP_K];
  logic [15:0] iq;
  logic [15:0] wq;
  logic [16:0] pq;

  logic [15:0] exp_tab [TAB];

  cell_ctrl_t         cell_ctrl;
  logic signed [31:0] cell_val [MAX_TOP_K];
  logic [15:0]        cell_idx [MAX_TOP_K];
  logic               cell_ge  [MAX_TOP_K];

  logic             div_go;
  logic [DIV_W-1:0] div_num;
  logic [TOT_W-1:0] div_den;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;

  logic             accept;
  logic             cfg_wr;
  logic [CNT_W-1:0] k_eff;
  logic             pen_app;
  logic [31:0]      x_mag;
  logic [47:0]      neg_prod;
  logic [39:0]      neg_m;
  logic [31:0]      pen_mag;
  logic [CNT_W-1:0] count_after;
  logic [32:0]      d_wide;
  logic [31:0]      d_cur;
  logic [15:0]      w_cur;
  logic [63:0]      xs1;
  logic [63:0]      xs2;
  logic [63:0]      xs3;
  logic             cut_mode;
  logic [CNT_W-1:0] act_n;
  logic [16:0]      total2;
  logic [17:0]      cum_sum;
  logic             hit;
  logic             i_last_n;
  logic             i_last_act;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    if (top_k == 7'd0) begin
      k_eff = CNT_W'(1);
    end else if (int'(top_k) > MAX_TOP_K) begin
      k_eff = CNT_W'(MAX_TOP_K);
    end else begin
      k_eff = CNT_W'(top_k);
    end
  end

  genvar g;
  generate
    for (g = 0; g < TAB; g++) begin : g_tab
      localparam logic [15:0] ENT = exp_entry(g, EXP_TABLE_BITS);
      assign exp_tab[g] = ENT;
    end

    for (g = 0; g < MAX_TOP_K; g++) begin : g_cell
      logic               pge;
      logic signed [31:0] pval;
      logic [15:0]        pidx;
      logic signed [31:0] nval;
      logic [15:0]        nidx;
      if (g == 0) begin : g_first
        assign pge  = 1'b1;
        assign pval = key_r;
        assign pidx = idx_r;
      end else begin : g_mid
        assign pge  = cell_ge[g-1];
        assign pval = cell_val[g-1];
        assign pidx = cell_idx[g-1];
      end
      if (g == MAX_TOP_K - 1) begin : g_end
        assign nval = cell_val[g];
        assign nidx = cell_idx[g];
      end else begin : g_next
        assign nval = cell_val[g+1];
        assign nidx = cell_idx[g+1];
      end
      tkps_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .key      (key_r),
        .key_idx  (idx_r),
        .occ      (CNT_W'(g) < kept_count),
        .prev_ge  (pge),
        .prev_val (pval),
        .prev_idx (pidx),
        .next_val (nval),
        .next_idx (nidx),
        .val      (cell_val[g]),
        .idx      (cell_idx[g]),
        .ge       (cell_ge[g])
      );
    end
  endgenerate

  tkps_div #(.DEN_W(TOT_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign pen_app  = seen_r && (rep_penalty > 16'd256);
  assign x_mag    = 32'(-x_r);
  assign neg_prod = 48'(x_mag) * 48'(rep_penalty);
  assign neg_m    = (neg_prod[47:8] > 40'h0080000000) ? 40'h0080000000 : neg_prod[47:8];
  assign pen_mag  = pen_r[31] ? 32'(-pen_r) : 32'(pen_r);

  assign count_after = (kept_count < CNT_W'(MAX_TOP_K)) ? kept_count + 1'b1 : kept_count;

  assign d_wide = {max_r[31], max_r} - {cell_val[0][31], cell_val[0]};
  assign d_cur  = (i_r == '0) ? 32'd0 : d_wide[31:0];
  assign w_cur  = (prod_r[48:32] < 17'd16)
                ? (exp_tab[prod_r[31:32-EXP_TABLE_BITS]] >> prod_r[35:32]) : 16'd0;

  assign xs1 = gen_state ^ (gen_state >> 12);
  assign xs2 = xs1 ^ (xs1 << 25);
  assign xs3 = xs2 ^ (xs2 >> 27);

  assign cut_mode   = !top_p[16];
  assign act_n      = cut_mode ? active_r : n_r;
  assign total2     = cut_mode ? cum_cut[16:0] : 17'd65536;
  assign cum_sum    = cum_r + {1'b0, pq};
  assign hit        = {cum_sum, 16'd0} >= {1'b0, t_r};
  assign i_last_n   = (CNT_W'(i_r) == n_r - 1'b1);
  assign i_last_act = (CNT_W'(i_r) == act_n - 1'b1);

  always_comb begin
    div_num = {1'b0, x_r[30:0], 8'd0};
    div_den = TOT_W'(rep_penalty);
    unique case (state)
      ST_KEY: begin
        div_num = {pen_mag, 8'd0};
        div_den = TOT_W'(temperature);
      end
      ST_PSTART: begin
        div_num = {8'd0, wq, 16'd0};
        div_den = (total_r == '0) ? TOT_W'(1) : total_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_go         = 1'b0;
    cell_ctrl.ins  = 1'b0;
    cell_ctrl.drain = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (pen_app && !x_r[31]) begin
          div_go     = 1'b1;
          state_next = ST_PEN;
        end else begin
          state_next = ST_KEY;
        end
      end
      ST_PEN: begin
        if (div_done) begin
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (greedy_r) begin
          state_next = ST_INS;
        end else begin
          div_go     = 1'b1;
          state_next = ST_TMP;
        end
      end
      ST_TMP: begin
        if (div_done) begin
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        cell_ctrl.ins = 1'b1;
        if (!last_r) begin
          state_next = ST_IDLE;
        end else if (greedy_r) begin
          state_next = ST_GRD;
        end else begin
          state_next = ST_WMUL;
        end
      end
      ST_GRD: begin
        state_next = ST_IDLE;
      end
      ST_WMUL: begin
        cell_ctrl.drain = 1'b1;
        state_next      = ST_WEXP;
      end
      ST_WEXP: begin
        state_next = i_last_n ? ST_PRD : ST_WMUL;
      end
      ST_PRD: begin
        state_next = ST_PSTART;
      end
      ST_PSTART: begin
        div_go     = 1'b1;
        state_next = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (div_done) begin
          state_next = i_last_n ? ST_RND0 : ST_PRD;
        end
      end
      ST_RND0: state_next = ST_RND1;
      ST_RND1: state_next = ST_RND2;
      ST_RND2: state_next = ST_RND3;
      ST_RND3: state_next = ST_RND4;
      ST_RND4: state_next = ST_TMUL;
      ST_TMUL: state_next = ST_SRD;
      ST_SRD:  state_next = ST_SCHK;
      ST_SCHK: begin
        state_next = (hit || i_last_act) ? ST_IDLE : ST_SRD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature   <= TEMPERATURE_RST;
      top_k         <= TOP_K_RST;
      top_p         <= TOP_P_RST;
      rep_penalty   <= PENALTY_RST;
      seed          <= SEED_RST;
      gen_state     <= SEED_RST;
      kept_count    <= '0;
      token_counter <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[5:3])
          REG_TEMPERATURE: temperature <= pwdata[15:0];
          REG_TOP_K:       top_k       <= pwdata[6:0];
          REG_TOP_P:       top_p       <= pwdata[16:0];
          REG_PENALTY:     rep_penalty <= pwdata[15:0];
          REG_SEED: begin
            seed      <= pwdata;
            gen_state <= pwdata;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_INS) begin
        if (last_r) begin
          kept_count    <= '0;
          token_counter <= '0;
        end else begin
          kept_count    <= count_after;
          token_counter <= (token_counter == TC_W'(VOCAB_MAX - 1))
                         ? '0 : token_counter + 1'b1;
        end
      end
      if (state == ST_RND0) begin
        gen_state <= xs3;
      end
      if (state == ST_GRD || (state == ST_SCHK && (hit || i_last_act))) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x_r      <= logit;
        seen_r   <= seen_flag;
        last_r   <= last_token;
        idx_r    <= 16'(token_counter);
        k_r      <= k_eff;
        greedy_r <= (temperature == 16'd0) || (k_eff == CNT_W'(1));
      end
      ST_PREP: begin
        if (pen_app && x_r[31]) begin
          pen_r <= 32'(-neg_m[31:0]);
        end else begin
          pen_r <= x_r;
        end
      end
      ST_PEN: begin
        if (div_done) begin
          pen_r <= div_quo[31:0];
        end
      end
      ST_KEY: begin
        key_r <= pen_r;
      end
      ST_TMP: begin
        if (div_done) begin
          if (pen_r[31]) begin
            key_r <= (div_quo > 40'h0080000000) ? 32'sh80000000 : 32'(-div_quo[31:0]);
          end else begin
            key_r <= (div_quo > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : div_quo[31:0];
          end
        end
      end
      ST_INS: begin
        n_r     <= (k_r < count_after) ? k_r : count_after;
        i_r     <= '0;
        total_r <= '0;
      end
      ST_GRD: begin
        token_index <= cell_idx[0];
      end
      ST_WMUL: begin
        if (i_r == '0) begin
          max_r <= cell_val[0];
        end
        prod_r <= 49'(d_cur) * 49'(LOG2E_Q16);
      end
      ST_WEXP: begin
        total_r <= total_r + TOT_W'(w_cur);
        if (i_last_n) begin
          i_r      <= '0;
          cum_cut  <= '0;
          active_r <= '0;
          cut_done <= 1'b0;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_PWAIT: begin
        if (div_done) begin
          if (!cut_done) begin
            cum_cut  <= cum_cut + {1'b0, div_quo[16:0]};
            active_r <= CNT_W'(i_r) + 1'b1;
            if (cum_cut + {1'b0, div_quo[16:0]} >= {1'b0, top_p}) begin
              cut_done <= 1'b1;
            end
          end
          if (!i_last_n) begin
            i_r <= i_r + 1'b1;
          end
        end
      end
      ST_RND1: begin
        rp0 <= 64'(gen_state[31:0]) * 64'(XS_MULT[31:0]);
      end
      ST_RND2: begin
        rph <= 32'(64'(gen_state[63:32]) * 64'(XS_MULT[31:0]));
      end
      ST_RND3: begin
        rph <= rph + 32'(64'(gen_state[31:0]) * 64'(XS_MULT[63:32]));
      end
      ST_RND4: begin
        r_r <= 16'((rp0 + {rph, 32'd0}) >> 48);
      end
      ST_TMUL: begin
        t_r   <= 33'(r_r) * 33'(total2);
        i_r   <= '0;
        cum_r <= '0;
      end
      ST_SCHK: begin
        cum_r <= cum_sum;
        i_r   <= i_r + 1'b1;
        if (hit || i_last_act) begin
          token_index <= iq;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_WMUL) begin
      idx_mem[i_r] <= cell_idx[0];
    end
    if (state == ST_WEXP) begin
      w_mem[i_r] <= w_cur;
    end
    if (state == ST_PWAIT && div_done) begin
      p_mem[i_r] <= div_quo[16:0];
    end
    iq <= idx_mem[i_r];
    wq <= w_mem[i_r];
    pq <= p_mem[i_r];
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_TEMPERATURE: prdata = 64'(temperature);
      REG_TOP_K:       prdata = 64'(top_k);
      REG_TOP_P:       prdata = 64'(top_p);
      REG_PENALTY:     prdata = 64'(rep_penalty);
      REG_SEED:        prdata = seed;
      default:         prdata = 64'd0;
    endcase
  end

endmodule

// File: src/tkps_checker.sv
module tkps_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A word that is taken keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result appears only once the work is finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // No result can follow an accepted word in the next cycle.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too soon after a word");

  // The strobe lasts a single cycle.
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind top_k_top_p_token_sampler tkps_checker u_tkps_checker (.*);
